// ----- design/aar_pkg.sv -----
// shared constants, types and tables for the rotation vector to matrix pipeline
package aar_pkg;

    localparam int IN_FRAC_BITS  = 12;
    localparam int OUT_FRAC_BITS = 14;
    localparam int TRIG_STAGES   = 16;
    localparam int ATAN_DEPTH    = 32;

    localparam int IN_W    = 16;
    localparam int LEN_W   = 16;
    localparam int LIMIT_W = 12;
    localparam int OUT_W   = 16;
    localparam int AXIS_W  = 32;
    localparam int TRIG_W  = 34;
    localparam int ANG_W   = 36;

    localparam int DIV_LATENCY = 33;
    localparam int COR_EXTRA   = 5;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [ANG_W-1:0]  angle_t;

    localparam angle_t Q30_PI      = 36'sd3373259426;
    localparam angle_t Q30_HALF_PI = 36'sd1686629713;
    localparam angle_t Q30_TWO_PI  = 36'sd6746518852;
    localparam angle_t Q30_FOUR_PI = 36'sd13493037704;
    localparam trig_t  CORDIC_GAIN = 34'sd652032874;
    localparam trig_t  Q30_ONE     = 34'sd1073741824;

    function automatic logic [31:0] atan_val(input int idx);
        unique case (idx)
            0:  return 32'd843314856;
            1:  return 32'd497837829;
            2:  return 32'd263043836;
            3:  return 32'd133525158;
            4:  return 32'd67021686;
            5:  return 32'd33543515;
            6:  return 32'd16775850;
            7:  return 32'd8388437;
            8:  return 32'd4194282;
            9:  return 32'd2097149;
            10: return 32'd1048575;
            11: return 32'd524287;
            12: return 32'd262143;
            13: return 32'd131071;
            14: return 32'd65535;
            15: return 32'd32767;
            16: return 32'd16383;
            17: return 32'd8191;
            18: return 32'd4095;
            19: return 32'd2047;
            20: return 32'd1023;
            21: return 32'd511;
            22: return 32'd255;
            23: return 32'd127;
            24: return 32'd63;
            25: return 32'd31;
            26: return 32'd15;
            27: return 32'd7;
            28: return 32'd3;
            29: return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

endpackage

// ----- design/aar_div.sv -----
// pipelined rounded divider that turns one vector component into a unit axis component
module aar_div #(
    parameter int PAD = 0
) (
    input  logic                               clk,
    input  logic signed [aar_pkg::IN_W-1:0]    w,
    input  logic [aar_pkg::LEN_W-1:0]          len,
    output aar_pkg::axis_t                     k
);
    import aar_pkg::*;

    localparam int QB = 31;

    logic [LEN_W-1:0] rem_reg [QB+1];
    logic [QB-1:0]    num_reg [QB+1];
    logic [QB-1:0]    quo_reg [QB+1];
    logic [LEN_W-1:0] den_reg [QB+1];
    logic             neg_reg [QB+1];
    axis_t            k_reg;
    logic [IN_W-1:0]  mag;

    assign mag = w[IN_W-1] ? IN_W'(-w) : IN_W'(w);

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {1'b0, mag[IN_W-1:1]};
        num_reg[0] <= {mag[0], 15'b0, len[LEN_W-1:1]};
        quo_reg[0] <= '0;
        den_reg[0] <= len;
        neg_reg[0] <= w[IN_W-1];
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_step
        logic [LEN_W:0] trial;
        logic           take;
        assign trial = {rem_reg[i-1], num_reg[i-1][QB-1]};
        assign take  = trial >= {1'b0, den_reg[i-1]};
        always_ff @(posedge clk)
        begin
            rem_reg[i] <= take ? LEN_W'(trial - {1'b0, den_reg[i-1]}) : trial[LEN_W-1:0];
            num_reg[i] <= {num_reg[i-1][QB-2:0], 1'b0};
            quo_reg[i] <= {quo_reg[i-1][QB-2:0], take};
            den_reg[i] <= den_reg[i-1];
            neg_reg[i] <= neg_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= neg_reg[QB] ? -axis_t'(quo_reg[QB]) : axis_t'(quo_reg[QB]);
    end

    if (PAD == 0)
    begin : g_nopad
        assign k = k_reg;
    end
    else
    begin : g_pad
        axis_t pad_reg [PAD];
        always_ff @(posedge clk)
        begin
            pad_reg[0] <= k_reg;
            for (int j = 1; j < PAD; j++)
            begin
                pad_reg[j] <= pad_reg[j-1];
            end
        end
        assign k = pad_reg[PAD-1];
    end

endmodule

// ----- design/aar_cordic.sv -----
// pipelined range reduction and rotation-mode cordic for sine and cosine of the length
module aar_cordic #(
    parameter int STAGES = aar_pkg::TRIG_STAGES,
    parameter int PAD    = 0
) (
    input  logic                      clk,
    input  logic [aar_pkg::LEN_W-1:0] len,
    output aar_pkg::trig_t            sin_val,
    output aar_pkg::trig_t            cos_val
);
    import aar_pkg::*;

    angle_t t0_reg, t1_reg, t2_reg;
    angle_t theta;
    trig_t  x_reg [STAGES+1];
    trig_t  y_reg [STAGES+1];
    angle_t t_reg [STAGES+1];
    logic   n_reg [STAGES+1];
    trig_t  s_reg, c_reg;

    assign theta = angle_t'({len, {(30-IN_FRAC_BITS){1'b0}}});

    always_ff @(posedge clk)
    begin
        t0_reg   <= (theta >= Q30_FOUR_PI) ? theta - Q30_FOUR_PI : theta;
        t1_reg   <= (t0_reg >= Q30_TWO_PI) ? t0_reg - Q30_TWO_PI : t0_reg;
        t2_reg   <= (t1_reg > Q30_PI) ? t1_reg - Q30_TWO_PI : t1_reg;
        x_reg[0] <= CORDIC_GAIN;
        y_reg[0] <= '0;
        if (t2_reg > Q30_HALF_PI)
        begin
            t_reg[0] <= Q30_PI - t2_reg;
            n_reg[0] <= 1'b1;
        end
        else if (t2_reg < -Q30_HALF_PI)
        begin
            t_reg[0] <= -Q30_PI - t2_reg;
            n_reg[0] <= 1'b1;
        end
        else
        begin
            t_reg[0] <= t2_reg;
            n_reg[0] <= 1'b0;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (t_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                t_reg[i+1] <= t_reg[i] - angle_t'(atan_val(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                t_reg[i+1] <= t_reg[i] + angle_t'(atan_val(i));
            end
            n_reg[i+1] <= n_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= y_reg[STAGES];
        c_reg <= n_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
    end

    if (PAD == 0)
    begin : g_nopad
        assign sin_val = s_reg;
        assign cos_val = c_reg;
    end
    else
    begin : g_pad
        trig_t ps_reg [PAD];
        trig_t pc_reg [PAD];
        always_ff @(posedge clk)
        begin
            ps_reg[0] <= s_reg;
            pc_reg[0] <= c_reg;
            for (int j = 1; j < PAD; j++)
            begin
                ps_reg[j] <= ps_reg[j-1];
                pc_reg[j] <= pc_reg[j-1];
            end
        end
        assign sin_val = ps_reg[PAD-1];
        assign cos_val = pc_reg[PAD-1];
    end

endmodule

// ----- design/axis_angle_to_rotation_matrix.sv -----
// top level: rotation vector to rotation matrix pipeline
// throughput: one transfer per cycle, busy is always low; latency is set by the 31-step
// divider and the cordic rotation stages that run side by side
// reset clears the valid pipeline and the small-angle limit; results in flight are dropped
// the receiver cannot stall: each result is on the ports for exactly one cycle with done
module axis_angle_to_rotation_matrix #(
    parameter int TRIG_STAGES = aar_pkg::TRIG_STAGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [aar_pkg::IN_W-1:0]   rot_x,
    input  logic signed [aar_pkg::IN_W-1:0]   rot_y,
    input  logic signed [aar_pkg::IN_W-1:0]   rot_z,
    input  logic                              cfg_we,
    input  logic [aar_pkg::LIMIT_W-1:0]       cfg_data,
    output logic                              done,
    output logic signed [aar_pkg::OUT_W-1:0]  m00,
    output logic signed [aar_pkg::OUT_W-1:0]  m01,
    output logic signed [aar_pkg::OUT_W-1:0]  m02,
    output logic signed [aar_pkg::OUT_W-1:0]  m10,
    output logic signed [aar_pkg::OUT_W-1:0]  m11,
    output logic signed [aar_pkg::OUT_W-1:0]  m12,
    output logic signed [aar_pkg::OUT_W-1:0]  m20,
    output logic signed [aar_pkg::OUT_W-1:0]  m21,
    output logic signed [aar_pkg::OUT_W-1:0]  m22,
    output logic                              is_identity
);
    import aar_pkg::*;

    localparam int COR_LAT = TRIG_STAGES + COR_EXTRA;
    localparam int LAT     = (COR_LAT > DIV_LATENCY) ? COR_LAT : DIV_LATENCY;
    localparam int LATENCY = 25 + LAT;
    localparam int SQ_W    = 32;
    localparam int RT      = 16;
    localparam int SH      = 30 - OUT_FRAC_BITS;
    localparam logic signed [35:0] OUT_LIM  = 36'sd1 <<< OUT_FRAC_BITS;
    localparam logic signed [35:0] OUT_HALF = 36'sd1 <<< (SH - 1);
    localparam logic [OUT_W-1:0]   ONE16    = OUT_W'(OUT_LIM);

    function automatic logic signed [67:0] rnd30(input logic signed [67:0] p);
        return (p + 68'sd536870912) >>> 30;
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = (v + OUT_HALF) >>> SH;
        if (r > OUT_LIM)
        begin
            r = OUT_LIM;
        end
        else if (r < -OUT_LIM)
        begin
            r = -OUT_LIM;
        end
        return r[OUT_W-1:0];
    endfunction

    logic [LIMIT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    assign busy = 1'b0;

    // input capture and squares
    logic                   v0_reg, v1_reg;
    logic signed [IN_W-1:0] wx0_reg, wy0_reg, wz0_reg, wx1_reg, wy1_reg, wz1_reg;
    logic [SQ_W-1:0]        px_reg, py_reg, pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wx0_reg <= rot_x;
        wy0_reg <= rot_y;
        wz0_reg <= rot_z;
        wx1_reg <= wx0_reg;
        wy1_reg <= wy0_reg;
        wz1_reg <= wz0_reg;
        px_reg  <= SQ_W'(wx0_reg * wx0_reg);
        py_reg  <= SQ_W'(wy0_reg * wy0_reg);
        pz_reg  <= SQ_W'(wz0_reg * wz0_reg);
    end

    // square root, one result bit per stage
    logic                   rv_reg  [RT+1];
    logic signed [IN_W-1:0] rx_reg  [RT+1];
    logic signed [IN_W-1:0] ry_reg  [RT+1];
    logic signed [IN_W-1:0] rz_reg  [RT+1];
    logic [SQ_W-1:0]        val_reg [RT+1];
    logic [RT:0]            rem_reg [RT+1];
    logic [RT-1:0]          root_reg[RT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg[0] <= 1'b0;
        end
        else
        begin
            rv_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg[0]   <= wx1_reg;
        ry_reg[0]   <= wy1_reg;
        rz_reg[0]   <= wz1_reg;
        val_reg[0]  <= px_reg + py_reg + pz_reg;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
    end

    for (genvar i = 1; i <= RT; i++)
    begin : g_sqrt
        logic [RT+2:0] cur;
        logic [RT+2:0] trial;
        logic          take;
        assign cur   = {rem_reg[i-1], val_reg[i-1][SQ_W-1:SQ_W-2]};
        assign trial = {1'b0, root_reg[i-1], 2'b01};
        assign take  = cur >= trial;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rv_reg[i] <= 1'b0;
            end
            else
            begin
                rv_reg[i] <= rv_reg[i-1];
            end
        end
        always_ff @(posedge clk)
        begin
            rx_reg[i]   <= rx_reg[i-1];
            ry_reg[i]   <= ry_reg[i-1];
            rz_reg[i]   <= rz_reg[i-1];
            val_reg[i]  <= {val_reg[i-1][SQ_W-3:0], 2'b00};
            rem_reg[i]  <= take ? (RT+1)'(cur - trial) : cur[RT:0];
            root_reg[i] <= {root_reg[i-1][RT-2:0], take};
        end
    end

    // axis and trig units side by side, aligned to LAT
    axis_t kx, ky, kz;
    trig_t s_val, c_val;

    aar_div #(.PAD(LAT - DIV_LATENCY)) u_div_x (
        .clk (clk),
        .w   (rx_reg[RT]),
        .len (root_reg[RT]),
        .k   (kx)
    );

    aar_div #(.PAD(LAT - DIV_LATENCY)) u_div_y (
        .clk (clk),
        .w   (ry_reg[RT]),
        .len (root_reg[RT]),
        .k   (ky)
    );

    aar_div #(.PAD(LAT - DIV_LATENCY)) u_div_z (
        .clk (clk),
        .w   (rz_reg[RT]),
        .len (root_reg[RT]),
        .k   (kz)
    );

    aar_cordic #(.STAGES(TRIG_STAGES), .PAD(LAT - COR_LAT)) u_cordic (
        .clk     (clk),
        .len     (root_reg[RT]),
        .sin_val (s_val),
        .cos_val (c_val)
    );

    logic [LAT-1:0] fv_reg, fi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else
        begin
            fv_reg <= {fv_reg[LAT-2:0], rv_reg[RT]};
        end
    end

    always_ff @(posedge clk)
    begin
        fi_reg <= {fi_reg[LAT-2:0], root_reg[RT] <= LEN_W'(limit_reg)};
    end

    // matrix assembly
    logic               va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic               ia_reg, ib_reg, ic_reg, id_reg, ie_reg;
    trig_t              ca_reg, cb_reg, cc_reg, cd_reg;
    logic signed [34:0] c1a_reg, c1b_reg;
    logic signed [63:0] pxx_reg, pyy_reg, pzz_reg, pxy_reg, pxz_reg, pyz_reg;
    logic signed [65:0] psx_reg, psy_reg, psz_reg;
    logic signed [32:0] rxx_reg, ryy_reg, rzz_reg, rxy_reg, rxz_reg, ryz_reg;
    logic signed [33:0] sxb_reg, syb_reg, szb_reg, sxc_reg, syc_reg, szc_reg;
    logic signed [33:0] sxd_reg, syd_reg, szd_reg;
    logic signed [67:0] qxx_reg, qyy_reg, qzz_reg, qxy_reg, qxz_reg, qyz_reg;
    logic signed [33:0] dxx_reg, dyy_reg, dzz_reg, dxy_reg, dxz_reg, dyz_reg;
    logic signed [35:0] e00_reg, e01_reg, e02_reg, e10_reg, e11_reg, e12_reg;
    logic signed [35:0] e20_reg, e21_reg, e22_reg;
    logic               done_reg, ident_reg;
    logic [OUT_W-1:0]   o00_reg, o01_reg, o02_reg, o10_reg, o11_reg, o12_reg;
    logic [OUT_W-1:0]   o20_reg, o21_reg, o22_reg;
    logic               ident_next;

    assign ident_next = ie_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
            vd_reg    <= 1'b0;
            ve_reg    <= 1'b0;
            done_reg  <= 1'b0;
            ident_reg <= 1'b0;
        end
        else
        begin
            va_reg    <= fv_reg[LAT-1];
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            vd_reg    <= vc_reg;
            ve_reg    <= vd_reg;
            done_reg  <= ve_reg;
            ident_reg <= ve_reg && ident_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ia_reg  <= fi_reg[LAT-1];
        ca_reg  <= c_val;
        c1a_reg <= 35'(Q30_ONE) - 35'(c_val);
        pxx_reg <= kx * kx;
        pyy_reg <= ky * ky;
        pzz_reg <= kz * kz;
        pxy_reg <= kx * ky;
        pxz_reg <= kx * kz;
        pyz_reg <= ky * kz;
        psx_reg <= kx * s_val;
        psy_reg <= ky * s_val;
        psz_reg <= kz * s_val;

        ib_reg  <= ia_reg;
        cb_reg  <= ca_reg;
        c1b_reg <= c1a_reg;
        rxx_reg <= 33'(rnd30(pxx_reg));
        ryy_reg <= 33'(rnd30(pyy_reg));
        rzz_reg <= 33'(rnd30(pzz_reg));
        rxy_reg <= 33'(rnd30(pxy_reg));
        rxz_reg <= 33'(rnd30(pxz_reg));
        ryz_reg <= 33'(rnd30(pyz_reg));
        sxb_reg <= 34'(rnd30(psx_reg));
        syb_reg <= 34'(rnd30(psy_reg));
        szb_reg <= 34'(rnd30(psz_reg));

        ic_reg  <= ib_reg;
        cc_reg  <= cb_reg;
        sxc_reg <= sxb_reg;
        syc_reg <= syb_reg;
        szc_reg <= szb_reg;
        qxx_reg <= rxx_reg * c1b_reg;
        qyy_reg <= ryy_reg * c1b_reg;
        qzz_reg <= rzz_reg * c1b_reg;
        qxy_reg <= rxy_reg * c1b_reg;
        qxz_reg <= rxz_reg * c1b_reg;
        qyz_reg <= ryz_reg * c1b_reg;

        id_reg  <= ic_reg;
        cd_reg  <= cc_reg;
        sxd_reg <= sxc_reg;
        syd_reg <= syc_reg;
        szd_reg <= szc_reg;
        dxx_reg <= 34'(rnd30(qxx_reg));
        dyy_reg <= 34'(rnd30(qyy_reg));
        dzz_reg <= 34'(rnd30(qzz_reg));
        dxy_reg <= 34'(rnd30(qxy_reg));
        dxz_reg <= 34'(rnd30(qxz_reg));
        dyz_reg <= 34'(rnd30(qyz_reg));

        ie_reg  <= id_reg;
        e00_reg <= 36'(cd_reg) + 36'(dxx_reg);
        e01_reg <= 36'(dxy_reg) - 36'(szd_reg);
        e02_reg <= 36'(dxz_reg) + 36'(syd_reg);
        e10_reg <= 36'(dxy_reg) + 36'(szd_reg);
        e11_reg <= 36'(cd_reg) + 36'(dyy_reg);
        e12_reg <= 36'(dyz_reg) - 36'(sxd_reg);
        e20_reg <= 36'(dxz_reg) - 36'(syd_reg);
        e21_reg <= 36'(dyz_reg) + 36'(sxd_reg);
        e22_reg <= 36'(cd_reg) + 36'(dzz_reg);

        // identity for lengths at or below the limit
        o00_reg <= ident_next ? ONE16 : to_out(e00_reg);
        o01_reg <= ident_next ? '0 : to_out(e01_reg);
        o02_reg <= ident_next ? '0 : to_out(e02_reg);
        o10_reg <= ident_next ? '0 : to_out(e10_reg);
        o11_reg <= ident_next ? ONE16 : to_out(e11_reg);
        o12_reg <= ident_next ? '0 : to_out(e12_reg);
        o20_reg <= ident_next ? '0 : to_out(e20_reg);
        o21_reg <= ident_next ? '0 : to_out(e21_reg);
        o22_reg <= ident_next ? ONE16 : to_out(e22_reg);
    end

    assign done        = done_reg;
    assign is_identity = ident_reg;
    assign m00 = o00_reg;
    assign m01 = o01_reg;
    assign m02 = o02_reg;
    assign m10 = o10_reg;
    assign m11 = o11_reg;
    assign m12 = o12_reg;
    assign m20 = o20_reg;
    assign m21 = o21_reg;
    assign m22 = o22_reg;

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(LATENCY) done)
        else $error("result transfer missing at fixed latency");

    a_ident_only_with_done : assert property (@(posedge clk) disable iff (!rst_n)
        is_identity |-> done)
        else $error("identity flag without result transfer");

    a_ident_matrix : assert property (@(posedge clk) disable iff (!rst_n)
        done && is_identity |-> m00 == ONE16 && m11 == ONE16 && m22 == ONE16 && m01 == '0)
        else $error("identity result has wrong entries");

    a_saturated : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> 36'(m01) <= OUT_LIM && 36'(m01) >= -OUT_LIM
              && 36'(m00) <= OUT_LIM && 36'(m00) >= -OUT_LIM)
        else $error("matrix entry beyond unit range");

endmodule

// ----- tb/tb_axis_angle_to_rotation_matrix.sv -----
// testbench for the rotation vector to rotation matrix pipeline with a self-checking scoreboard
`timescale 1ns / 1ps

module tb_axis_angle_to_rotation_matrix;
    import aar_pkg::*;

    typedef struct {
        logic [15:0] m [9];
        logic        ident;
    } rot_matrix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic signed [15:0] rot_x = '0, rot_y = '0, rot_z = '0;
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_data = '0;
    logic        done;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic        is_identity;
    int          n_errors = 0;
    bit          quiet = 1'b0;

    always #2 clk = ~clk;

    axis_angle_to_rotation_matrix DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
        .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22), .is_identity(is_identity)
    );

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic longint fl_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return rnd_shift(a * b, 30);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 60;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint atan_entry(int i);
        longint t[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
            131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
            31, 15, 7, 3, 1};
        return (i < 30) ? t[i] : 0;
    endfunction

    function automatic void cordic_sin_cos(longint theta, output longint s, output longint c);
        longint t, x, y, nx;
        bit     flip;
        t = theta % longint'(Q30_TWO_PI);
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 1'b0;
        if (t > longint'(Q30_PI)) t = t - longint'(Q30_TWO_PI);
        if (t > longint'(Q30_HALF_PI))
        begin
            t = longint'(Q30_PI) - t;
            flip = 1'b1;
        end
        else if (t < -longint'(Q30_HALF_PI))
        begin
            t = -longint'(Q30_PI) - t;
            flip = 1'b1;
        end
        for (int i = 0; i < (TRIG_STAGES > 32 ? 32 : TRIG_STAGES); i++)
        begin
            if (t >= 0)
            begin
                nx = x - fl_shift(y, i);
                y = y + fl_shift(x, i);
                t = t - atan_entry(i);
            end
            else
            begin
                nx = x + fl_shift(y, i);
                y = y - fl_shift(x, i);
                t = t + atan_entry(i);
            end
            x = nx;
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic longint div_rnd(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic logic [15:0] to_q14(longint v);
        longint r, lim;
        r = rnd_shift(v, 30 - OUT_FRAC_BITS);
        lim = longint'(1) << OUT_FRAC_BITS;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[15:0];
    endfunction

    function automatic rot_matrix_t rodrigues(logic [11:0] lim, longint wx, longint wy,
                                              longint wz);
        rot_matrix_t e;
        longint len, kx, ky, kz, s, c, c1, xy, xz, yz, one;
        len = int_sqrt(wx * wx + wy * wy + wz * wz);
        if (len <= longint'(lim))
        begin
            for (int i = 0; i < 9; i++)
                e.m[i] = (i % 4 == 0) ? 16'(1 << OUT_FRAC_BITS) : 16'd0;
            e.ident = 1'b1;
            return e;
        end
        one = longint'(Q30_ONE);
        kx = div_rnd(wx * one, len);
        ky = div_rnd(wy * one, len);
        kz = div_rnd(wz * one, len);
        cordic_sin_cos(len << (30 - IN_FRAC_BITS), s, c);
        c1 = one - c;
        xy = mul_q30(mul_q30(kx, ky), c1);
        xz = mul_q30(mul_q30(kx, kz), c1);
        yz = mul_q30(mul_q30(ky, kz), c1);
        e.m[0] = to_q14(c + mul_q30(mul_q30(kx, kx), c1));
        e.m[1] = to_q14(-mul_q30(kz, s) + xy);
        e.m[2] = to_q14(mul_q30(ky, s) + xz);
        e.m[3] = to_q14(mul_q30(kz, s) + xy);
        e.m[4] = to_q14(c + mul_q30(mul_q30(ky, ky), c1));
        e.m[5] = to_q14(-mul_q30(kx, s) + yz);
        e.m[6] = to_q14(-mul_q30(ky, s) + xz);
        e.m[7] = to_q14(mul_q30(kx, s) + yz);
        e.m[8] = to_q14(c + mul_q30(mul_q30(kz, kz), c1));
        e.ident = 1'b0;
        return e;
    endfunction

    class matrix_scoreboard;
        logic [11:0] angle_limit = '0;
        rot_matrix_t pending[$];

        function void note_transfer(logic signed [15:0] x, logic signed [15:0] y,
                                    logic signed [15:0] z);
            pending.push_back(rodrigues(angle_limit, x, y, z));
        endfunction

        task check_result(rot_matrix_t got);
            rot_matrix_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no transfer pending");
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.m[i] !== e.m[i])
                    report_mismatch($sformatf("m%0d%0d got %0d expected %0d", i / 3, i % 3,
                        $signed(got.m[i]), $signed(e.m[i])));
            if (got.ident !== e.ident)
                report_mismatch($sformatf("is_identity got %b expected %b", got.ident,
                    e.ident));
        endtask
    endclass

    matrix_scoreboard sb = new();

    always @(posedge clk)
    begin
        rot_matrix_t r;
        if (start && !busy)
            sb.note_transfer(rot_x, rot_y, rot_z);
        if (done)
        begin
            r.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
            r.ident = is_identity;
            sb.check_result(r);
        end
    end

    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        rot_x <= x;
        rot_y <= y;
        rot_z <= z;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_and_write(logic [11:0] lim);
        int guard;
        guard = 0;
        start <= 1'b0;
        while (sb.pending.size() != 0 && guard < 10000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (70) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= lim;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.angle_limit = lim;
    endtask

    task automatic random_vector(int scale);
        logic signed [15:0] v[3];
        for (int j = 0; j < 3; j++)
            case (scale)
                0: v[j] = 16'($urandom_range(0, 8)) - 16'sd4;
                1: v[j] = 16'($urandom_range(0, 4000)) - 16'sd2000;
                default: v[j] = 16'($urandom);
            endcase
        send_vector(v[0], v[1], v[2]);
    endtask

    initial
    begin
        logic [11:0] limits[5] = '{12'd0, 12'd4095, 12'd50, 12'd3, 12'd1};
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_vector(0, 0, 0);
        send_vector(16'sh7fff, 0, 0);
        send_vector(16'sh8000, 0, 0);
        send_vector(0, 16'sh7fff, 0);
        send_vector(0, 0, 16'sh8000);
        send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vector(16'sh8000, 16'sh8000, 16'sh8000);
        send_vector(1, 0, 0);
        send_vector(0, -1, 0);
        send_vector(12868, 0, 0);
        send_vector(0, 6434, 0);
        send_vector(0, 0, -6434);
        send_vector(25736, 0, 0);
        send_vector(-1, -1, -1);
        send_vector(16'sh5555, 16'shaaaa, 16'sh1234);

        foreach (limits[p])
        begin
            drain_and_write(limits[p]);
            for (int i = 0; i < 340; i++)
            begin
                quiet = (p == 4 && i > 200);
                random_vector(p == 2 && i % 2 == 0 ? 1 : $urandom_range(0, 2));
            end
            if (p == 2)
                send_vector(50, 0, 0);
        end
        quiet = 1'b0;
        start <= 1'b0;

        while (sb.pending.size() != 0) @(negedge clk);
        repeat (70) @(negedge clk);
        if (n_errors == 0)
            $display("axis_angle_to_rotation_matrix test passed");
        else
            $display("axis_angle_to_rotation_matrix test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("axis_angle_to_rotation_matrix test failed");
        $finish;
    end
endmodule
